// ----- sv/rtsch_pkg.sv -----
`default_nettype none
package rtsch_pkg;

  localparam int NUM_TASKS = 16;
  localparam int NUM_PRIO  = 8;
  localparam int TID_W     = $clog2(NUM_TASKS);
  localparam int PRIO_W    = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;

  // Widths of the channel fields.
  localparam int KIND_W  = 4;
  localparam int FTID_W  = 4;
  localparam int FPRIO_W = 3;
  localparam int SLICE_W = 8;
  localparam int WORD_W  = 32;
  localparam int POL_W   = 2;

  localparam logic [POL_W-1:0] POL_RR     = 2'd0;
  localparam logic [POL_W-1:0] POL_PRE    = 2'd1;
  localparam logic [POL_W-1:0] POL_HYBRID = 2'd2;

  typedef enum logic [2:0] {
    ST_UNUSED = 3'd0,
    ST_READY  = 3'd1,
    ST_RUN    = 3'd2,
    ST_SLEEP  = 3'd3,
    ST_WAIT   = 3'd4,
    ST_ZOMBIE = 3'd5
  } task_st_t;

  typedef enum logic [KIND_W-1:0] {
    EV_CREATE = 4'd0,
    EV_TICK   = 4'd1,
    EV_YIELD  = 4'd2,
    EV_SLEEPU = 4'd3,
    EV_SLEEPF = 4'd4,
    EV_WAIT   = 4'd5,
    EV_SET    = 4'd6,
    EV_EXIT   = 4'd7,
    EV_START  = 4'd8
  } ev_kind_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CREATE,
    OP_WAKE,
    OP_SLEEP,
    OP_WAITC,
    OP_WAITB,
    OP_SETEV,
    OP_EXIT,
    OP_REQUEUE,
    OP_DISPATCH,
    OP_SLICE
  } cell_op_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_EXEC,
    FS_TWAKE,
    FS_TSLICE,
    FS_REQ,
    FS_LEVEL,
    FS_SCAN,
    FS_DONE
  } fsm_st_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_t            op;
    logic [TID_W-1:0]    tgt;
    logic [PRIO_W-1:0]   prio;
    logic [SLICE_W-1:0]  slice;
    logic [WORD_W-1:0]   wake;
    logic [WORD_W-1:0]   mask;
    logic [WORD_W-1:0]   tick;
  } cmd_t;

  // Status that each cell shows to the sequencer.
  typedef struct packed {
    task_st_t            state;
    logic [PRIO_W-1:0]   prio;
    logic [SLICE_W-1:0]  reload;
    logic [SLICE_W-1:0]  remain;
    logic                hit;
  } cell_stat_t;

endpackage
`default_nettype wire

// ----- sv/rtsch_if.sv -----
`default_nettype none
interface rtsch_in_if;
  logic                              valid;
  logic                              ready;
  logic [rtsch_pkg::KIND_W-1:0]      kind;
  logic [rtsch_pkg::FTID_W-1:0]      task_id;
  logic [rtsch_pkg::FPRIO_W-1:0]     priority_req;
  logic [rtsch_pkg::SLICE_W-1:0]     slice_ticks;
  logic [rtsch_pkg::WORD_W-1:0]      wake_time;
  logic [rtsch_pkg::WORD_W-1:0]      event_mask;
  modport source(output valid, kind, task_id, priority_req, slice_ticks, wake_time,
                 event_mask, input ready);
  modport sink(input valid, kind, task_id, priority_req, slice_ticks, wake_time,
               event_mask, output ready);
endinterface

interface rtsch_out_if;
  logic                              valid;
  logic                              ready;
  logic [rtsch_pkg::FTID_W-1:0]      running_tid;
  logic                              running_valid;
  logic                              switched;
  logic [rtsch_pkg::FTID_W-1:0]      created_tid;
  logic                              create_failed;
  logic                              events_consumed;
  logic                              start_error;
  logic [rtsch_pkg::WORD_W-1:0]      tick_count;
  modport source(output valid, running_tid, running_valid, switched, created_tid,
                 create_failed, events_consumed, start_error, tick_count, input ready);
  modport sink(input valid, running_tid, running_valid, switched, created_tid,
               create_failed, events_consumed, start_error, tick_count, output ready);
endinterface
`default_nettype wire

// ----- sv/rtsch_cell.sv -----
`default_nettype none
module rtsch_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [rtsch_pkg::TID_W-1:0]     idx,
  input  wire rtsch_pkg::cmd_t                 cmd,
  input  wire logic                            found_in,
  output logic                                 found_out,
  input  wire logic [rtsch_pkg::NUM_PRIO-1:0]  lvl_in,
  output logic [rtsch_pkg::NUM_PRIO-1:0]       lvl_out,
  output logic                                 take,
  output rtsch_pkg::cell_stat_t                stat
);

  rtsch_pkg::task_st_t                state_r, state_nxt;
  logic [rtsch_pkg::PRIO_W-1:0]       prio_r, prio_nxt;
  logic [rtsch_pkg::SLICE_W-1:0]      reload_r, reload_nxt;
  logic [rtsch_pkg::SLICE_W-1:0]      remain_r, remain_nxt;
  logic [rtsch_pkg::WORD_W-1:0]       wake_r, wake_nxt;
  logic [rtsch_pkg::WORD_W-1:0]       pend_r, pend_nxt;
  logic [rtsch_pkg::WORD_W-1:0]       waited_r, waited_nxt;
  logic [rtsch_pkg::WORD_W-1:0]       since;
  logic                               sel;

  // The search for the first unused slot ripples along the row.
  assign take      = (state_r == rtsch_pkg::ST_UNUSED) && !found_in;
  assign found_out = found_in || (state_r == rtsch_pkg::ST_UNUSED);
  assign sel       = (cmd.tgt == idx);
  assign since     = cmd.tick - wake_r;

  always_comb begin
    lvl_out = lvl_in;
    if (state_r == rtsch_pkg::ST_READY) begin
      lvl_out[prio_r] = 1'b1;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    prio_nxt   = prio_r;
    reload_nxt = reload_r;
    remain_nxt = remain_r;
    wake_nxt   = wake_r;
    pend_nxt   = pend_r;
    waited_nxt = waited_r;
    case (cmd.op)
      rtsch_pkg::OP_CREATE: begin
        if (take) begin
          state_nxt  = rtsch_pkg::ST_READY;
          prio_nxt   = cmd.prio;
          reload_nxt = cmd.slice;
          remain_nxt = cmd.slice;
          wake_nxt   = '0;
          pend_nxt   = '0;
          waited_nxt = '0;
        end
      end
      rtsch_pkg::OP_WAKE: begin
        if (state_r == rtsch_pkg::ST_SLEEP && !since[rtsch_pkg::WORD_W-1]) begin
          state_nxt = rtsch_pkg::ST_READY;
        end
      end
      rtsch_pkg::OP_SLEEP: begin
        if (sel) begin
          wake_nxt  = cmd.wake;
          state_nxt = rtsch_pkg::ST_SLEEP;
        end
      end
      rtsch_pkg::OP_WAITC: begin
        if (sel) begin
          pend_nxt = pend_r & ~cmd.mask;
        end
      end
      rtsch_pkg::OP_WAITB: begin
        if (sel) begin
          waited_nxt = cmd.mask;
          state_nxt  = rtsch_pkg::ST_WAIT;
        end
      end
      rtsch_pkg::OP_SETEV: begin
        if (sel) begin
          pend_nxt = pend_r | cmd.mask;
          if (state_r == rtsch_pkg::ST_WAIT && ((pend_r | cmd.mask) & waited_r) != '0) begin
            state_nxt = rtsch_pkg::ST_READY;
          end
        end
      end
      rtsch_pkg::OP_EXIT: begin
        if (sel) begin
          state_nxt = rtsch_pkg::ST_ZOMBIE;
        end
      end
      rtsch_pkg::OP_REQUEUE: begin
        if (sel && state_r == rtsch_pkg::ST_RUN) begin
          state_nxt = rtsch_pkg::ST_READY;
        end
      end
      rtsch_pkg::OP_DISPATCH: begin
        if (sel) begin
          state_nxt  = rtsch_pkg::ST_RUN;
          pend_nxt   = pend_r & ~waited_r;
          waited_nxt = '0;
        end
      end
      rtsch_pkg::OP_SLICE: begin
        if (sel) begin
          remain_nxt = (remain_r <= rtsch_pkg::SLICE_W'(1)) ? reload_r
                                                            : remain_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rtsch_pkg::ST_UNUSED;
      prio_r   <= '0;
      reload_r <= '0;
      remain_r <= '0;
      wake_r   <= '0;
      pend_r   <= '0;
      waited_r <= '0;
    end else begin
      state_r  <= state_nxt;
      prio_r   <= prio_nxt;
      reload_r <= reload_nxt;
      remain_r <= remain_nxt;
      wake_r   <= wake_nxt;
      pend_r   <= pend_nxt;
      waited_r <= waited_nxt;
    end
  end

  assign stat.state  = state_r;
  assign stat.prio   = prio_r;
  assign stat.reload = reload_r;
  assign stat.remain = remain_r;
  assign stat.hit    = (pend_r & cmd.mask) != '0;

endmodule
`default_nettype wire

// ----- sv/rtos_task_scheduler_top.sv -----
// Each item runs through the sequencer states: create, set events, a wait that consumes,
// start without dispatch and unknown kinds finish in the execute state; a tick then wakes
// sleepers and checks the slice. Sleep, wait that blocks, exit and start pick a level and
// scan the slots for a ready task; a yield and a switching tick first requeue the runner.
// One item at a time; the next item is accepted in the cycle after its result loads.
// Reset (rst_n low at a clock edge) empties all slots, clears tick and pointers, sets hybrid.
`default_nettype none
module rtos_task_scheduler_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rtsch_in_if.sink                           in_ch,
  rtsch_out_if.source                        out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [rtsch_pkg::POL_W-1:0]   cfg_wdata
);

  localparam int NT = rtsch_pkg::NUM_TASKS;
  localparam int NP = rtsch_pkg::NUM_PRIO;
  localparam int TW = rtsch_pkg::TID_W;
  localparam int PW = rtsch_pkg::PRIO_W;

  // The row of task cells. Each cell hands the "free slot found" flag and the
  // vector of ready priority levels to its right neighbor.
  rtsch_pkg::cmd_t        cmd;
  rtsch_pkg::cell_stat_t  stat [NT];
  logic                   found_c [NT+1];
  logic [NP-1:0]          lvl_c [NT+1];
  logic [NT-1:0]          take;

  assign found_c[0] = 1'b0;
  assign lvl_c[0]   = '0;

  for (genvar g = 0; g < NT; g++) begin : g_cell
    rtsch_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (TW'(g)),
      .cmd       (cmd),
      .found_in  (found_c[g]),
      .found_out (found_c[g+1]),
      .lvl_in    (lvl_c[g]),
      .lvl_out   (lvl_c[g+1]),
      .take      (take[g]),
      .stat      (stat[g])
    );
  end

  // Control and scheduler state.
  rtsch_pkg::fsm_st_t              st_r, st_nxt;
  logic [rtsch_pkg::POL_W-1:0]     pol_r;
  logic [rtsch_pkg::WORD_W-1:0]    tick_r, tick_nxt;
  logic [TW-1:0]                   cur_r, cur_nxt;
  logic                            cval_r, cval_nxt;
  logic [TW-1:0]                   rr_r [NP];
  logic                            rr_we;

  // The item under work.
  logic [rtsch_pkg::KIND_W-1:0]    kind_r;
  logic [rtsch_pkg::FTID_W-1:0]    tid_in_r;
  logic [rtsch_pkg::FPRIO_W-1:0]   prio_req_r;
  logic [rtsch_pkg::SLICE_W-1:0]   slice_r;
  logic [rtsch_pkg::WORD_W-1:0]    wt_r;
  logic [rtsch_pkg::WORD_W-1:0]    em_r;

  // Result flags and scan state.
  logic                            sw_r, sw_nxt;
  logic                            cfail_r, cfail_nxt;
  logic                            cons_r, cons_nxt;
  logic                            serr_r, serr_nxt;
  logic [TW-1:0]                   ctid_r, ctid_nxt;
  logic [PW-1:0]                   level_r, level_nxt;
  logic [TW-1:0]                   base_r, base_nxt;
  logic [TW-1:0]                   k_r, k_nxt;

  // Output register.
  logic                            ov_r;
  logic                            out_load;
  logic [rtsch_pkg::FTID_W-1:0]    o_tid_r, o_ctid_r;
  logic                            o_rv_r, o_sw_r, o_cfail_r, o_cons_r, o_serr_r;
  logic [rtsch_pkg::WORD_W-1:0]    o_tick_r;

  // Decoded helpers.
  logic                            pol_rr, pol_pre;
  logic [NP-1:0]                   lvl_vec;
  logic [TW-1:0]                   slot;
  logic [PW-1:0]                   best;
  logic                            hi_ready, hieq_ready;
  logic [TW:0]                     scan_sum;
  logic [TW-1:0]                   scan_tid;
  logic [TW:0]                     base_sum;
  logic [TW-1:0]                   rr_next;
  logic                            scan_hit;
  rtsch_pkg::cell_stat_t           cur_st;
  logic                            expire;
  logic [PW-1:0]                   prio_cl;
  logic [rtsch_pkg::SLICE_W-1:0]   slice_cl;

  assign pol_rr  = (pol_r == rtsch_pkg::POL_RR);
  assign pol_pre = (pol_r == rtsch_pkg::POL_PRE);
  assign lvl_vec = lvl_c[NT];
  assign cur_st  = stat[cur_r];
  assign expire  = (cur_st.reload != '0) && (cur_st.remain <= rtsch_pkg::SLICE_W'(1));

  always_comb begin
    slot = '0;
    for (int i = 0; i < NT; i++) begin
      if (take[i]) begin
        slot = slot | TW'(i);
      end
    end
  end

  // Best ready level, and whether a level above (or at) the running task's is ready.
  always_comb begin
    best       = '0;
    hi_ready   = 1'b0;
    hieq_ready = 1'b0;
    for (int j = NP - 1; j >= 0; j--) begin
      if (lvl_vec[j]) begin
        best = PW'(j);
      end
    end
    for (int j = 0; j < NP; j++) begin
      if (lvl_vec[j] && PW'(j) < cur_st.prio) begin
        hi_ready = 1'b1;
      end
      if (lvl_vec[j] && PW'(j) <= cur_st.prio) begin
        hieq_ready = 1'b1;
      end
    end
  end

  // Round-robin scan position, wrapped at the number of slots.
  always_comb begin
    scan_sum = {1'b0, base_r} + {1'b0, k_r};
    if (scan_sum >= (TW+1)'(NT)) begin
      scan_sum = scan_sum - (TW+1)'(NT);
    end
    scan_tid = scan_sum[TW-1:0];
    scan_hit = (stat[scan_tid].state == rtsch_pkg::ST_READY) &&
               (stat[scan_tid].prio == level_r);
  end

  always_comb begin
    base_sum = {1'b0, rr_r[best]} + (TW+1)'(1);
    if (base_sum >= (TW+1)'(NT)) begin
      base_sum = base_sum - (TW+1)'(NT);
    end
    rr_next = base_sum[TW-1:0];
  end

  // A created task's priority is clamped, and forced to zero under flat round robin.
  always_comb begin
    if (pol_rr) begin
      prio_cl = '0;
    end else if (32'(prio_req_r) >= NP) begin
      prio_cl = PW'(NP - 1);
    end else begin
      prio_cl = PW'(prio_req_r);
    end
    if (pol_pre) begin
      slice_cl = '0;
    end else if (slice_r == '0) begin
      slice_cl = rtsch_pkg::SLICE_W'(1);
    end else begin
      slice_cl = slice_r;
    end
  end

  assign in_ch.ready = (st_r == rtsch_pkg::FS_IDLE);
  assign out_load    = (st_r == rtsch_pkg::FS_DONE) && (!ov_r || out_ch.ready);

  // Sequencer: issues one command to the row per cycle.
  always_comb begin
    st_nxt    = st_r;
    tick_nxt  = tick_r;
    cur_nxt   = cur_r;
    cval_nxt  = cval_r;
    sw_nxt    = sw_r;
    cfail_nxt = cfail_r;
    cons_nxt  = cons_r;
    serr_nxt  = serr_r;
    ctid_nxt  = ctid_r;
    level_nxt = level_r;
    base_nxt  = base_r;
    k_nxt     = k_r;
    rr_we     = 1'b0;
    cmd.op    = rtsch_pkg::OP_NOP;
    cmd.tgt   = cur_r;
    cmd.prio  = prio_cl;
    cmd.slice = slice_cl;
    cmd.wake  = (kind_r == rtsch_pkg::EV_SLEEPU) ? wt_r : tick_r + wt_r;
    cmd.mask  = em_r;
    cmd.tick  = tick_r;
    unique case (st_r)
      rtsch_pkg::FS_IDLE: begin
        if (in_ch.valid) begin
          sw_nxt    = 1'b0;
          cfail_nxt = 1'b0;
          cons_nxt  = 1'b0;
          serr_nxt  = 1'b0;
          ctid_nxt  = '0;
          st_nxt    = rtsch_pkg::FS_EXEC;
        end
      end
      rtsch_pkg::FS_EXEC: begin
        st_nxt = rtsch_pkg::FS_DONE;
        case (kind_r)
          rtsch_pkg::EV_CREATE: begin
            if (!found_c[NT]) begin
              cfail_nxt = 1'b1;
            end else begin
              cmd.op   = rtsch_pkg::OP_CREATE;
              ctid_nxt = slot;
            end
          end
          rtsch_pkg::EV_TICK: begin
            tick_nxt = tick_r + 1'b1;
            st_nxt   = rtsch_pkg::FS_TWAKE;
          end
          rtsch_pkg::EV_YIELD: begin
            if (cval_r) begin
              sw_nxt = 1'b1;
              st_nxt = rtsch_pkg::FS_REQ;
            end
          end
          rtsch_pkg::EV_SLEEPU, rtsch_pkg::EV_SLEEPF: begin
            if (cval_r) begin
              cmd.op = rtsch_pkg::OP_SLEEP;
              sw_nxt = 1'b1;
              st_nxt = rtsch_pkg::FS_LEVEL;
            end
          end
          rtsch_pkg::EV_WAIT: begin
            if (cval_r) begin
              if (cur_st.hit) begin
                cmd.op   = rtsch_pkg::OP_WAITC;
                cons_nxt = 1'b1;
              end else begin
                cmd.op = rtsch_pkg::OP_WAITB;
                sw_nxt = 1'b1;
                st_nxt = rtsch_pkg::FS_LEVEL;
              end
            end
          end
          rtsch_pkg::EV_SET: begin
            if (32'(tid_in_r) < NT) begin
              cmd.op  = rtsch_pkg::OP_SETEV;
              cmd.tgt = TW'(tid_in_r);
            end
          end
          rtsch_pkg::EV_EXIT: begin
            if (cval_r) begin
              cmd.op = rtsch_pkg::OP_EXIT;
              sw_nxt = 1'b1;
              st_nxt = rtsch_pkg::FS_LEVEL;
            end
          end
          rtsch_pkg::EV_START: begin
            if (stat[0].state == rtsch_pkg::ST_UNUSED) begin
              serr_nxt = 1'b1;
            end else if (!cval_r) begin
              sw_nxt = 1'b1;
              st_nxt = rtsch_pkg::FS_LEVEL;
            end
          end
          default: begin
          end
        endcase
      end
      rtsch_pkg::FS_TWAKE: begin
        cmd.op = rtsch_pkg::OP_WAKE;
        st_nxt = rtsch_pkg::FS_TSLICE;
      end
      rtsch_pkg::FS_TSLICE: begin
        st_nxt = rtsch_pkg::FS_DONE;
        if (cval_r) begin
          if (!pol_pre) begin
            if (cur_st.reload != '0) begin
              cmd.op = rtsch_pkg::OP_SLICE;
              if (expire && hieq_ready) begin
                sw_nxt = 1'b1;
                st_nxt = rtsch_pkg::FS_REQ;
              end
            end
          end else if (hi_ready) begin
            sw_nxt = 1'b1;
            st_nxt = rtsch_pkg::FS_REQ;
          end
        end
      end
      rtsch_pkg::FS_REQ: begin
        cmd.op = rtsch_pkg::OP_REQUEUE;
        st_nxt = rtsch_pkg::FS_LEVEL;
      end
      rtsch_pkg::FS_LEVEL: begin
        level_nxt = pol_rr ? '0 : best;
        base_nxt  = pol_pre ? '0 : (pol_rr ? rr_next : rr_next);
        k_nxt     = '0;
        cur_nxt   = '0;
        if (pol_rr) begin
          base_nxt = rr_next;
        end
        if (lvl_vec == '0) begin
          // Nothing is ready: slot zero runs, whatever its state.
          cmd.op   = rtsch_pkg::OP_NOP;
          cur_nxt  = '0;
          cval_nxt = 1'b1;
          st_nxt   = rtsch_pkg::FS_SCAN;
          k_nxt    = TW'(NT - 1);
          level_nxt = '0;
          base_nxt  = '0;
        end else begin
          st_nxt = rtsch_pkg::FS_SCAN;
        end
      end
      rtsch_pkg::FS_SCAN: begin
        if (scan_hit && lvl_vec != '0) begin
          cmd.op   = rtsch_pkg::OP_DISPATCH;
          cmd.tgt  = scan_tid;
          cur_nxt  = scan_tid;
          cval_nxt = 1'b1;
          rr_we    = !pol_pre;
          st_nxt   = rtsch_pkg::FS_DONE;
        end else if (k_r == TW'(NT - 1)) begin
          cmd.op   = rtsch_pkg::OP_DISPATCH;
          cmd.tgt  = '0;
          cur_nxt  = '0;
          cval_nxt = 1'b1;
          st_nxt   = rtsch_pkg::FS_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      rtsch_pkg::FS_DONE: begin
        if (out_load) begin
          st_nxt = rtsch_pkg::FS_IDLE;
        end
      end
      default: begin
        st_nxt = rtsch_pkg::FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= rtsch_pkg::FS_IDLE;
      pol_r  <= rtsch_pkg::POL_HYBRID;
      tick_r <= '0;
      cur_r  <= '0;
      cval_r <= 1'b0;
      ov_r   <= 1'b0;
      for (int p = 0; p < NP; p++) begin
        rr_r[p] <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      tick_r <= tick_nxt;
      cur_r  <= cur_nxt;
      cval_r <= cval_nxt;
      if (cfg_we) begin
        pol_r <= cfg_wdata;
      end
      if (rr_we) begin
        rr_r[level_r] <= scan_tid;
      end
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r     <= in_ch.kind;
      tid_in_r   <= in_ch.task_id;
      prio_req_r <= in_ch.priority_req;
      slice_r    <= in_ch.slice_ticks;
      wt_r       <= in_ch.wake_time;
      em_r       <= in_ch.event_mask;
    end
    sw_r    <= sw_nxt;
    cfail_r <= cfail_nxt;
    cons_r  <= cons_nxt;
    serr_r  <= serr_nxt;
    ctid_r  <= ctid_nxt;
    level_r <= level_nxt;
    base_r  <= base_nxt;
    k_r     <= k_nxt;
    if (out_load) begin
      o_tid_r   <= rtsch_pkg::FTID_W'(cur_r);
      o_rv_r    <= cval_r;
      o_sw_r    <= sw_r;
      o_ctid_r  <= rtsch_pkg::FTID_W'(ctid_r);
      o_cfail_r <= cfail_r;
      o_cons_r  <= cons_r;
      o_serr_r  <= serr_r;
      o_tick_r  <= tick_r;
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.running_tid     = o_tid_r;
  assign out_ch.running_valid   = o_rv_r;
  assign out_ch.switched        = o_sw_r;
  assign out_ch.created_tid     = o_ctid_r;
  assign out_ch.create_failed   = o_cfail_r;
  assign out_ch.events_consumed = o_cons_r;
  assign out_ch.start_error     = o_serr_r;
  assign out_ch.tick_count      = o_tick_r;

endmodule
`default_nettype wire

// ----- sv/rtsch_chk.sv -----
`default_nettype none
module rtsch_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        running_valid,
  input wire logic        switched,
  input wire logic [3:0]  created_tid,
  input wire logic        create_failed,
  input wire logic [31:0] tick_count
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tick_count))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && switched |-> running_valid)
    else $error("switch without a running task");

  a_cfail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && create_failed |-> created_tid == 4'd0)
    else $error("failed create reports a slot");

endmodule

bind rtos_task_scheduler_top rtsch_chk u_rtsch_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .running_valid (out_ch.running_valid),
  .switched      (out_ch.switched),
  .created_tid   (out_ch.created_tid),
  .create_failed (out_ch.create_failed),
  .tick_count    (out_ch.tick_count)
);
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  // The run stops at this many clock cycles. The slowest correct run is far below it:
  // about 1400 items, taken one at a time, plus sender gaps and receiver stalls.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 40;
  localparam logic [rtsch_pkg::POL_W-1:0] POL_ALIAS = 2'd3;  // Undefined code, behaves as hybrid.
  localparam logic [rtsch_pkg::KIND_W-1:0] FIRST_UNKNOWN_KIND = 4'd9;

  typedef struct packed {
    logic [3:0]  running_tid;
    logic        running_valid;
    logic        switched;
    logic [3:0]  created_tid;
    logic        create_failed;
    logic        events_consumed;
    logic        start_error;
    logic [31:0] tick_count;
  } sched_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rtsch_pkg::POL_W-1:0] cfg_wdata;

  rtsch_in_if  in_ch ();
  rtsch_out_if out_ch ();

  rtos_task_scheduler_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // The clock runs with a 2 ns period for the whole simulation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow. This mirrors every slot of the task table, the ready
  // bitmaps and round-robin pointers, so that each accepted item can be turned
  // into the result the block must return.
  // ---------------------------------------------------------------------------
  logic [rtsch_pkg::POL_W-1:0] sh_policy;
  rtsch_pkg::task_st_t sh_state  [rtsch_pkg::NUM_TASKS];
  logic [2:0]       sh_prio   [rtsch_pkg::NUM_TASKS];
  logic [7:0]       sh_reload [rtsch_pkg::NUM_TASKS];
  logic [7:0]       sh_remain [rtsch_pkg::NUM_TASKS];
  logic [31:0]      sh_wake   [rtsch_pkg::NUM_TASKS];
  logic [31:0]      sh_pend   [rtsch_pkg::NUM_TASKS];
  logic [31:0]      sh_waited [rtsch_pkg::NUM_TASKS];
  logic [15:0]      sh_ready  [rtsch_pkg::NUM_PRIO];
  logic [3:0]       sh_rrptr  [rtsch_pkg::NUM_PRIO];
  logic [3:0]       sh_cur;
  logic             sh_cur_valid;
  logic [31:0]      sh_tick;

  sched_result_t expected_results[$];
  int            errors;
  int            cycles;
  int            burst_left;

  // Policy codes at or above hybrid all behave as hybrid.
  function automatic logic [rtsch_pkg::POL_W-1:0] active_policy();
    return (sh_policy >= rtsch_pkg::POL_HYBRID) ? rtsch_pkg::POL_HYBRID : sh_policy;
  endfunction

  function automatic void make_ready(int t);
    sh_ready[sh_prio[t]][t] = 1'b1;
    sh_state[t] = rtsch_pkg::ST_READY;
  endfunction

  function automatic void unready(int t);
    sh_ready[sh_prio[t]][t] = 1'b0;
  endfunction

  // Returns the next ready slot after the level's pointer, or NUM_TASKS if none.
  function automatic int rotate_level(int p);
    int t;
    for (int k = 0; k < rtsch_pkg::NUM_TASKS; k++) begin
      t = (sh_rrptr[p] + 1 + k) % rtsch_pkg::NUM_TASKS;
      if (sh_ready[p][t]) begin
        sh_rrptr[p] = t[3:0];
        return t;
      end
    end
    return rtsch_pkg::NUM_TASKS;
  endfunction

  function automatic int choose_next();
    int  t;
    logic any;
    any = 1'b0;
    for (int p = 0; p < rtsch_pkg::NUM_PRIO; p++) if (sh_ready[p] != '0) any = 1'b1;
    if (!any) return 0;
    if (active_policy() == rtsch_pkg::POL_RR) begin
      t = rotate_level(0);
      return (t < rtsch_pkg::NUM_TASKS) ? t : 0;
    end
    for (int p = 0; p < rtsch_pkg::NUM_PRIO; p++) begin
      if (sh_ready[p] == '0) continue;
      if (active_policy() == rtsch_pkg::POL_PRE) begin
        for (int i = 0; i < rtsch_pkg::NUM_TASKS; i++) if (sh_ready[p][i]) return i;
        continue;
      end
      t = rotate_level(p);
      if (t < rtsch_pkg::NUM_TASKS) return t;
    end
    return 0;
  endfunction

  function automatic logic better_level_ready(int pr);
    for (int p = 0; p < pr; p++) if (sh_ready[p] != '0) return 1'b1;
    return 1'b0;
  endfunction

  // A dispatched task drops the events it was waiting for.
  function automatic void dispatch();
    int n;
    if (sh_cur_valid && sh_state[sh_cur] == rtsch_pkg::ST_RUN) make_ready(sh_cur);
    n = choose_next();
    unready(n);
    sh_state[n]  = rtsch_pkg::ST_RUN;
    sh_cur       = n[3:0];
    sh_cur_valid = 1'b1;
    sh_pend[n]   = sh_pend[n] & ~sh_waited[n];
    sh_waited[n] = '0;
  endfunction

  function automatic void clear_shadow();
    sh_policy = rtsch_pkg::POL_HYBRID;
    for (int t = 0; t < rtsch_pkg::NUM_TASKS; t++) begin
      sh_state[t] = rtsch_pkg::ST_UNUSED;
      sh_prio[t] = '0; sh_reload[t] = '0; sh_remain[t] = '0;
      sh_wake[t] = '0; sh_pend[t] = '0; sh_waited[t] = '0;
    end
    for (int p = 0; p < rtsch_pkg::NUM_PRIO; p++) begin
      sh_ready[p] = '0;
      sh_rrptr[p] = '0;
    end
    sh_cur = '0;
    sh_cur_valid = 1'b0;
    sh_tick = '0;
  endfunction

  function automatic sched_result_t apply_event(logic [3:0] kind, logic [3:0] tid,
                                                logic [2:0] pr, logic [7:0] sl,
                                                logic [31:0] wt, logic [31:0] em);
    sched_result_t r;
    int   slot;
    int   c;
    logic need;
    r = '0;
    c = sh_cur;
    case (kind)
      rtsch_pkg::EV_CREATE: begin
        slot = rtsch_pkg::NUM_TASKS;
        for (int t = 0; t < rtsch_pkg::NUM_TASKS; t++) begin
          if (sh_state[t] == rtsch_pkg::ST_UNUSED) begin
            slot = t;
            break;
          end
        end
        if (slot == rtsch_pkg::NUM_TASKS) begin
          r.create_failed = 1'b1;
        end else begin
          sh_prio[slot]   = (active_policy() == rtsch_pkg::POL_RR) ? 3'd0 : pr;
          sh_pend[slot]   = '0;
          sh_waited[slot] = '0;
          sh_wake[slot]   = '0;
          // Preemptive tasks are never sliced; a zero slice means one tick.
          if (active_policy() == rtsch_pkg::POL_PRE) begin
            sh_reload[slot] = '0;
            sh_remain[slot] = '0;
          end else begin
            sh_reload[slot] = (sl == 0) ? 8'd1 : sl;
            sh_remain[slot] = sh_reload[slot];
          end
          make_ready(slot);
          r.created_tid = slot[3:0];
        end
      end
      rtsch_pkg::EV_TICK: begin
        need = 1'b0;
        sh_tick = sh_tick + 1;
        // Wake ticks are compared in wrapping arithmetic.
        for (int t = 0; t < rtsch_pkg::NUM_TASKS; t++)
          if (sh_state[t] == rtsch_pkg::ST_SLEEP && !((sh_tick - sh_wake[t]) >> 31))
            make_ready(t);
        if (sh_cur_valid) begin
          if (active_policy() != rtsch_pkg::POL_PRE) begin
            if (sh_reload[c] != 0) begin
              if (sh_remain[c] > 0) sh_remain[c] = sh_remain[c] - 1;
              if (sh_remain[c] == 0) begin
                sh_remain[c] = sh_reload[c];
                if (better_level_ready(sh_prio[c]) ||
                    (sh_ready[sh_prio[c]] & ~(16'd1 << c)) != 0) need = 1'b1;
              end
            end
          end else if (better_level_ready(sh_prio[c])) begin
            need = 1'b1;
          end
        end
        if (need) begin
          dispatch();
          r.switched = 1'b1;
        end
      end
      rtsch_pkg::EV_YIELD: begin
        if (sh_cur_valid) begin
          dispatch();
          r.switched = 1'b1;
        end
      end
      rtsch_pkg::EV_SLEEPU, rtsch_pkg::EV_SLEEPF: begin
        if (sh_cur_valid) begin
          sh_wake[c]  = (kind == rtsch_pkg::EV_SLEEPU) ? wt : sh_tick + wt;
          sh_state[c] = rtsch_pkg::ST_SLEEP;
          unready(c);
          dispatch();
          r.switched = 1'b1;
        end
      end
      rtsch_pkg::EV_WAIT: begin
        if (sh_cur_valid) begin
          if ((sh_pend[c] & em) != 0) begin
            sh_pend[c] = sh_pend[c] & ~em;
            r.events_consumed = 1'b1;
          end else begin
            sh_waited[c] = em;
            sh_state[c]  = rtsch_pkg::ST_WAIT;
            unready(c);
            dispatch();
            r.switched = 1'b1;
          end
        end
      end
      rtsch_pkg::EV_SET: begin
        sh_pend[tid] = sh_pend[tid] | em;
        if (sh_state[tid] == rtsch_pkg::ST_WAIT && (sh_pend[tid] & sh_waited[tid]) != 0)
          make_ready(tid);
      end
      rtsch_pkg::EV_EXIT: begin
        if (sh_cur_valid) begin
          sh_state[c] = rtsch_pkg::ST_ZOMBIE;
          unready(c);
          dispatch();
          r.switched = 1'b1;
        end
      end
      rtsch_pkg::EV_START: begin
        if (sh_state[0] == rtsch_pkg::ST_UNUSED) begin
          r.start_error = 1'b1;
        end else if (!sh_cur_valid) begin
          dispatch();
          r.switched = 1'b1;
        end
      end
      default: ;
    endcase
    r.running_tid   = sh_cur_valid ? sh_cur : 4'd0;
    r.running_valid = sh_cur_valid;
    r.tick_count    = sh_tick;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Each call presents one item and holds it until it is accepted.
  // Items go out in bursts; when a burst ends, valid drops for a random gap.
  // ---------------------------------------------------------------------------
  task automatic send_event(logic [3:0] kind, logic [3:0] tid, logic [2:0] pr,
                            logic [7:0] sl, logic [31:0] wt, logic [31:0] em);
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.task_id      <= tid;
    in_ch.priority_req <= pr;
    in_ch.slice_ticks  <= sl;
    in_ch.wake_time    <= wt;
    in_ch.event_mask   <= em;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(apply_event(kind, tid, pr, sl, wt, em));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // Now and then a long burst gives a stretch with no gaps at all.
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // Shorthand for items whose only relevant field is the kind.
  task automatic send_plain(logic [3:0] kind);
    send_event(kind, 4'($urandom), 3'($urandom), 8'($urandom), $urandom, $urandom);
  endtask

  // Holds the sender back until every expected result has been returned, then
  // lets the block finish any trailing work.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_policy(logic [rtsch_pkg::POL_W-1:0] pol);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= pol;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sh_policy = pol;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result checking. The ready pattern switches between always
  // ready, random stalls and a periodic stall.
  // ---------------------------------------------------------------------------
  int stall_mode;
  int stall_phase;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase  <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result item arrived with no item outstanding", $realtime);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.running_tid != want.running_tid)
            report("running_tid", out_ch.running_tid, want.running_tid);
          if (out_ch.running_valid != want.running_valid)
            report("running_valid", out_ch.running_valid, want.running_valid);
          if (out_ch.switched != want.switched)
            report("switched", out_ch.switched, want.switched);
          if (out_ch.created_tid != want.created_tid)
            report("created_tid", out_ch.created_tid, want.created_tid);
          if (out_ch.create_failed != want.create_failed)
            report("create_failed", out_ch.create_failed, want.create_failed);
          if (out_ch.events_consumed != want.events_consumed)
            report("events_consumed", out_ch.events_consumed, want.events_consumed);
          if (out_ch.start_error != want.start_error)
            report("start_error", out_ch.start_error, want.start_error);
          if (out_ch.tick_count != want.tick_count)
            report("tick_count", out_ch.tick_count, want.tick_count);
        end
      end
      if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 2) != 0);
        default: out_ch.ready <= (stall_phase % 7) < 3;
      endcase
    end
  end

  // The run is cut off if it takes far longer than a correct block would.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // With no task running, start fails, the task calls are ignored and a tick
  // only counts. Undefined kinds change nothing.
  task automatic test_empty_table();
    send_plain(rtsch_pkg::EV_START);
    send_plain(rtsch_pkg::EV_YIELD);
    send_plain(rtsch_pkg::EV_SLEEPU);
    send_plain(rtsch_pkg::EV_SLEEPF);
    send_plain(rtsch_pkg::EV_WAIT);
    send_plain(rtsch_pkg::EV_EXIT);
    send_plain(rtsch_pkg::EV_TICK);
    send_event(rtsch_pkg::EV_SET, 4'd15, 3'd0, 8'd0, 32'd0, 32'hFFFF_FFFF);
    for (int k = FIRST_UNKNOWN_KIND; k <= 15; k++) send_plain(4'(k));
  endtask

  // One pass through the life of a few tasks: create at the priority extremes
  // with both slice extremes, start twice (the second time while running), then
  // tick, yield, both sleeps, a wait that finds its events pending, a blocking
  // wait woken by set events, a wait on an empty mask and an exit.
  task automatic test_task_lifecycle();
    send_event(rtsch_pkg::EV_CREATE, 4'd0, 3'd0, 8'd0, 32'd0, 32'd0);
    send_event(rtsch_pkg::EV_CREATE, 4'd0, 3'd7, 8'd255, 32'd0, 32'd0);
    send_event(rtsch_pkg::EV_CREATE, 4'd0, 3'd0, 8'd2, 32'd0, 32'd0);
    send_plain(rtsch_pkg::EV_START);
    send_plain(rtsch_pkg::EV_START);
    send_plain(rtsch_pkg::EV_TICK);
    send_plain(rtsch_pkg::EV_TICK);
    send_plain(rtsch_pkg::EV_YIELD);
    send_event(rtsch_pkg::EV_SLEEPU, 4'd0, 3'd0, 8'd0, sh_tick + 2, 32'd0);
    send_event(rtsch_pkg::EV_SLEEPF, 4'd0, 3'd0, 8'd0, 32'd0, 32'd0);
    send_plain(rtsch_pkg::EV_TICK);
    send_plain(rtsch_pkg::EV_TICK);
    send_event(rtsch_pkg::EV_SET, sh_cur, 3'd0, 8'd0, 32'd0, 32'h8000_0001);
    send_event(rtsch_pkg::EV_WAIT, 4'd0, 3'd0, 8'd0, 32'd0, 32'h8000_0000);
    send_event(rtsch_pkg::EV_WAIT, 4'd0, 3'd0, 8'd0, 32'd0, 32'h0000_0010);
    send_event(rtsch_pkg::EV_SET, 4'd1, 3'd0, 8'd0, 32'd0, 32'h0000_0010);
    send_event(rtsch_pkg::EV_SET, 4'd2, 3'd0, 8'd0, 32'd0, 32'h0000_0010);
    send_event(rtsch_pkg::EV_WAIT, 4'd0, 3'd0, 8'd0, 32'd0, 32'd0);
    send_event(rtsch_pkg::EV_SLEEPF, 4'd0, 3'd0, 8'd0, 32'hFFFF_FFFF, 32'd0);
    send_plain(rtsch_pkg::EV_EXIT);
    send_plain(rtsch_pkg::EV_TICK);
  endtask

  // Random traffic under one policy. Most items are ticks, sleeps, waits and
  // matching set events with small masks so that tasks keep cycling through the
  // ready, sleeping and waiting states; a few use the full field ranges.
  task automatic test_random_traffic(logic [rtsch_pkg::POL_W-1:0] pol, int count);
    int          sel;
    logic [3:0]  kind;
    logic [31:0] wt;
    logic [31:0] em;
    write_policy(pol);
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      wt  = $urandom_range(0, 6);
      em  = 32'd1 << $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) em = $urandom;
      if      (sel < 30) kind = rtsch_pkg::EV_TICK;
      else if (sel < 40) kind = rtsch_pkg::EV_YIELD;
      else if (sel < 45) begin
        kind = rtsch_pkg::EV_SLEEPU;
        wt = ($urandom_range(0, 7) == 0) ? $urandom : sh_tick + $urandom_range(0, 6);
      end
      else if (sel < 53) begin
        kind = rtsch_pkg::EV_SLEEPF;
        if ($urandom_range(0, 15) == 0) wt = $urandom;
      end
      else if (sel < 65) kind = rtsch_pkg::EV_WAIT;
      else if (sel < 80) kind = rtsch_pkg::EV_SET;
      else if (sel < 82) kind = rtsch_pkg::EV_EXIT;
      else if (sel < 92) kind = rtsch_pkg::EV_CREATE;
      else if (sel < 96) kind = rtsch_pkg::EV_START;
      else kind = 4'($urandom_range(FIRST_UNKNOWN_KIND, 15));
      send_event(kind, 4'($urandom), 3'($urandom),
                 ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
                 wt, em);
    end
  endtask

  // Creates until the table refuses, then shows that a full table stays full.
  task automatic test_table_full();
    for (int i = 0; i <= rtsch_pkg::NUM_TASKS; i++) send_plain(rtsch_pkg::EV_CREATE);
    send_plain(rtsch_pkg::EV_TICK);
  endtask

  initial begin
    errors       = 0;
    cycles       = 0;
    burst_left   = 0;
    stall_mode   = 0;
    clear_shadow();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= '0;
    in_ch.task_id      <= '0;
    in_ch.priority_req <= '0;
    in_ch.slice_ticks  <= '0;
    in_ch.wake_time    <= '0;
    in_ch.event_mask   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_empty_table();
    test_task_lifecycle();
    test_random_traffic(rtsch_pkg::POL_RR, 300);
    test_random_traffic(rtsch_pkg::POL_PRE, 350);
    test_random_traffic(POL_ALIAS, 300);
    test_random_traffic(rtsch_pkg::POL_HYBRID, 350);
    test_table_full();
    test_random_traffic(rtsch_pkg::POL_PRE, 60);

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
